[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the millisecond timer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rtcms_pkg.sv]
// ----------------------------------------------------------------------------
// rtcms_pkg
// Types, operation codes and constants for the RTC millisecond timer.
// ----------------------------------------------------------------------------
package rtcms_pkg;

  // Operation codes carried in tuser
  localparam logic [2:0] FUNC_CLEAR     = 3'd0;
  localparam logic [2:0] FUNC_READ32    = 3'd1;
  localparam logic [2:0] FUNC_READ16    = 3'd2;
  localparam logic [2:0] FUNC_ELAPSED32 = 3'd3;
  localparam logic [2:0] FUNC_ELAPSED16 = 3'd4;

  // Configuration register indexes
  localparam logic CFG_SHORT_WRAP = 1'b0;
  localparam logic CFG_RATE_SEL   = 1'b1;

  // Short counter wrap point
  localparam logic [31:0] SHORT_WRAP_POINT = 32'hA8C0_0000;

  // Milliseconds per full counter wrap
  localparam logic [31:0] WRAP_MS_FULL_FAST  = 32'd131072000;
  localparam logic [31:0] WRAP_MS_FULL_SLOW  = 32'd134217728;
  localparam logic [31:0] WRAP_MS_SHORT_FAST = 32'd86400000;
  localparam logic [31:0] WRAP_MS_SHORT_SLOW = 32'd88473600;

  typedef struct packed {
    logic short_wrap;   // counter wraps at SHORT_WRAP_POINT
    logic rate_sel;     // 0: 32768 Hz, 1: 32000 Hz
  } cfg_t;

  // Payload handed from the state stage to the output stage
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] elapsed;
    logic [31:0] offset_ms;
    logic [31:0] reference_ms;
  } stage_t;

  // Millisecond length of one counter wrap
  function automatic logic [31:0] wrap_ms(input logic short_wrap, input logic rate_sel);
    logic [31:0] ms;
    case ({short_wrap, rate_sel})
      2'b00:   ms = WRAP_MS_FULL_FAST;
      2'b01:   ms = WRAP_MS_FULL_SLOW;
      2'b10:   ms = WRAP_MS_SHORT_FAST;
      default: ms = WRAP_MS_SHORT_SLOW;
    endcase
    return ms;
  endfunction

endpackage

[design/rtcms_state.sv]
// ----------------------------------------------------------------------------
// rtcms_state
// Tick base, previous elapsed count and wrap offset, plus the first
// pipeline register holding the operation, elapsed count, offset and reference for the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcms_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtcms_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_func,
  input  logic [31:0]           in_ticks,
  input  logic [31:0]           in_reference_ms,
  output logic                  st_valid,
  input  logic                  st_ready,
  output rtcms_pkg::stage_t     st_data
);

  logic [31:0]       tick_base_r, tick_base_nxt;
  logic [31:0]       prev_elapsed_r, prev_elapsed_nxt;
  logic [31:0]       wrap_offset_r, wrap_offset_nxt;
  logic              st_valid_r;
  rtcms_pkg::stage_t st_data_r, st_data_nxt;
  logic              accept;
  logic              is_read;
  logic [31:0]       elapsed;

  // Stage can take a new transaction when empty or draining this cycle
  assign in_ready = !st_valid_r || st_ready;
  assign accept   = in_valid && in_ready;
  assign st_valid = st_valid_r;
  assign st_data  = st_data_r;

  assign is_read = (in_func == rtcms_pkg::FUNC_READ32) ||
                   (in_func == rtcms_pkg::FUNC_READ16) ||
                   (in_func == rtcms_pkg::FUNC_ELAPSED32) ||
                   (in_func == rtcms_pkg::FUNC_ELAPSED16);

  // Ticks since base, modulo the wrap point
  always_comb begin
    if (cfg.short_wrap && (in_ticks < tick_base_r)) begin
      elapsed = (rtcms_pkg::SHORT_WRAP_POINT - tick_base_r) + in_ticks;
    end else begin
      elapsed = in_ticks - tick_base_r;
    end
  end

  // State update for clear and read operations
  always_comb begin
    tick_base_nxt    = tick_base_r;
    prev_elapsed_nxt = prev_elapsed_r;
    wrap_offset_nxt  = wrap_offset_r;
    if (in_func == rtcms_pkg::FUNC_CLEAR) begin
      tick_base_nxt    = in_ticks;
      prev_elapsed_nxt = '0;
      wrap_offset_nxt  = '0;
    end else if (is_read) begin
      prev_elapsed_nxt = elapsed;
      if (elapsed < prev_elapsed_r) begin
        wrap_offset_nxt = wrap_offset_r + rtcms_pkg::wrap_ms(cfg.short_wrap, cfg.rate_sel);
      end
    end
    st_data_nxt.func         = in_func;
    st_data_nxt.elapsed      = elapsed;
    st_data_nxt.offset_ms    = wrap_offset_nxt;
    st_data_nxt.reference_ms = in_reference_ms;
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_base_r    <= '0;
      prev_elapsed_r <= '0;
      wrap_offset_r  <= '0;
    end else if (accept) begin
      tick_base_r    <= tick_base_nxt;
      prev_elapsed_r <= prev_elapsed_nxt;
      wrap_offset_r  <= wrap_offset_nxt;
    end
  end

  // Pipeline register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_data_r <= st_data_nxt;
    end
  end

  `ASSERT_NEXT(a_clear_zeroes, clk, rst_n, accept && (in_func == rtcms_pkg::FUNC_CLEAR), (prev_elapsed_r == 32'd0) && (wrap_offset_r == 32'd0), "clear did not zero the state")
  `ASSERT_NEXT(a_base_only_on_clear, clk, rst_n, !(accept && (in_func == rtcms_pkg::FUNC_CLEAR)), $stable(tick_base_r), "tick base changed without a clear")
  `ASSERT_NEXT(a_stage_holds, clk, rst_n, st_valid_r && !st_ready, st_valid_r && $stable(st_data_r), "stage register lost a stalled transaction")

endmodule

[design/rtc_tick_millisecond_timer.sv]
// ----------------------------------------------------------------------------
// rtc_tick_millisecond_timer
// Millisecond timer built on a free-running RTC tick counter.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries an RTC reading and a reference time in
//   in_tdata and an operation code in in_tuser (clear, read32, read16,
//   elapsed32, elapsed16). Every input transaction yields exactly one output
//   transaction on out_tdata, in order; clear and unused codes return zero.
//   Configuration (wrap mode, tick rate) is written on the cfg_ port while
//   the block is idle, one register per cycle, no read-back.
// Pipeline and throughput:
//   Two register stages: the state stage updates base, previous elapsed
//   count and wrap offset at acceptance; the output stage converts ticks to
//   milliseconds (constant multiply by 125 and shift, or shift by 5) and
//   applies the offset and reference. One transaction is accepted every
//   cycle unless both registers are full and out_tready is low.
// Reset and stalls:
//   Synchronous active-low reset clears the state and both configuration
//   registers and empties the pipeline. When out_tready is low the output
//   register and stage register hold; in_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc_tick_millisecond_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] rtc_ticks, [63:32] reference_ms
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] time_ms
);

  rtcms_pkg::cfg_t   cfg_r;
  rtcms_pkg::stage_t st_data;
  logic              st_valid;
  logic              st_ready;
  logic              out_valid_r;
  logic [31:0]       out_data_r, out_data_nxt;
  logic [38:0]       prod;
  logic [26:0]       ms;
  logic [31:0]       total;
  logic [31:0]       since_ref;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtcms_pkg::CFG_SHORT_WRAP: cfg_r.short_wrap <= cfg_wdata;
        rtcms_pkg::CFG_RATE_SEL:   cfg_r.rate_sel   <= cfg_wdata;
        default:                   cfg_r            <= cfg_r;
      endcase
    end
  end

  rtcms_state u_state (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_func         (in_tuser),
    .in_ticks        (in_tdata[31:0]),
    .in_reference_ms (in_tdata[63:32]),
    .st_valid        (st_valid),
    .st_ready        (st_ready),
    .st_data         (st_data)
  );

  // Ticks to ms: x*1000/32768 = (x*125)>>12, x*1000/32000 = x>>5
  assign prod = ({7'd0, st_data.elapsed} << 7) - ({7'd0, st_data.elapsed} << 1)
              - ({7'd0, st_data.elapsed} << 0);
  assign ms   = cfg_r.rate_sel ? st_data.elapsed[31:5] : prod[38:12];

  assign total     = {5'd0, ms} + st_data.offset_ms;
  assign since_ref = total - st_data.reference_ms;

  // Result selection by operation
  always_comb begin
    case (st_data.func)
      rtcms_pkg::FUNC_READ32:    out_data_nxt = total;
      rtcms_pkg::FUNC_READ16:    out_data_nxt = {16'd0, total[15:0]};
      rtcms_pkg::FUNC_ELAPSED32: out_data_nxt = since_ref;
      rtcms_pkg::FUNC_ELAPSED16: out_data_nxt = {16'd0, since_ref[15:0]};
      default:                   out_data_nxt = '0;
    endcase
  end

  // Output register
  assign st_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready) begin
      out_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_SAME(a_ready_only_when_full, clk, rst_n, !in_tready, st_valid && out_valid_r && !out_tready, "input stalled while the pipeline had room")
  `ASSERT_NEXT(a_stage_moves, clk, rst_n, st_valid && st_ready, out_valid_r, "stage transaction was not taken into the output register")
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid_r && !out_tready, out_valid_r && $stable(out_data_r), "stalled result changed")

endmodule

[tb/sv/rtcms_time_checker.sv]
// ----------------------------------------------------------------------------
// rtcms_time_checker
// Watches the configuration port and both stream channels of the RTC
// millisecond timer. Every accepted input transaction runs through a local
// model of the timer state (tick base, previous elapsed count, wrap offset)
// and queues the expected time_ms. Each accepted output transaction is
// compared with the oldest queued value.
// ----------------------------------------------------------------------------
module rtcms_time_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] rtc_ticks, [63:32] reference_ms
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] time_ms
  output int          fail_count,
  output int          pending_count
);

  localparam logic [63:0] TICK_HZ_FAST = 64'd32768;
  localparam logic [63:0] TICK_HZ_SLOW = 64'd32000;
  localparam logic [63:0] MS_PER_SEC   = 64'd1000;
  localparam logic [63:0] FULL_WRAP    = 64'h1_0000_0000;

  // Model copy of configuration and timer state
  logic        mdl_short_wrap;
  logic        mdl_rate_sel;
  logic [31:0] mdl_tick_base;
  logic [31:0] mdl_prev_elapsed;
  logic [31:0] mdl_wrap_ms;

  logic [31:0] expected_time_q[$];
  logic [31:0] exp_time;

  // Tick count to milliseconds at the selected rate, truncating
  function automatic logic [31:0] ticks_to_msec(input logic [63:0] ticks);
    logic [63:0] rate;
    logic [63:0] quot;
    rate = mdl_rate_sel ? TICK_HZ_SLOW : TICK_HZ_FAST;
    quot = (ticks * MS_PER_SEC) / rate;
    return quot[31:0];
  endfunction

  // Millisecond reading for one read operation; updates the wrap tracking
  function automatic logic [31:0] read_msec(input logic [31:0] now);
    logic [31:0] elapsed;
    if (!mdl_short_wrap || now >= mdl_tick_base)
      elapsed = now - mdl_tick_base;
    else
      elapsed = (rtcms_pkg::SHORT_WRAP_POINT - mdl_tick_base) + now;
    // counter went backwards: one wrap has passed
    if (elapsed < mdl_prev_elapsed)
      mdl_wrap_ms = mdl_wrap_ms +
                    ticks_to_msec(mdl_short_wrap ? {32'h0, rtcms_pkg::SHORT_WRAP_POINT}
                                                 : FULL_WRAP);
    mdl_prev_elapsed = elapsed;
    return ticks_to_msec({32'h0, elapsed}) + mdl_wrap_ms;
  endfunction

  // Expected time_ms for one input transaction
  function automatic logic [31:0] advance_timer(input logic [2:0] func,
                                                input logic [31:0] now,
                                                input logic [31:0] ref_ms);
    logic [31:0] msec;
    logic [31:0] res;
    res = '0;
    case (func)
      rtcms_pkg::FUNC_CLEAR: begin
        mdl_tick_base    = now;
        mdl_prev_elapsed = '0;
        mdl_wrap_ms      = '0;
      end
      rtcms_pkg::FUNC_READ32: res = read_msec(now);
      rtcms_pkg::FUNC_READ16: begin
        msec = read_msec(now);
        res  = {16'h0, msec[15:0]};
      end
      rtcms_pkg::FUNC_ELAPSED32: res = read_msec(now) - ref_ms;
      rtcms_pkg::FUNC_ELAPSED16: begin
        msec = read_msec(now) - ref_ms;
        res  = {16'h0, msec[15:0]};
      end
      default: res = '0;  // unused codes leave the state alone
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_short_wrap   = 1'b0;
      mdl_rate_sel     = 1'b0;
      mdl_tick_base    = '0;
      mdl_prev_elapsed = '0;
      mdl_wrap_ms      = '0;
      expected_time_q.delete();
    end else begin
      // result side
      if (out_tvalid && out_tready) begin
        if (expected_time_q.size() == 0) begin
          $error("time_ms: result with nothing expected, actual %0d", out_tdata);
          fail_count = fail_count + 1;
        end else begin
          exp_time = expected_time_q.pop_front();
          if (out_tdata !== exp_time) begin
            $error("time_ms mismatch: expected %0d, actual %0d", exp_time, out_tdata);
            fail_count = fail_count + 1;
          end
        end
      end
      // register writes
      if (cfg_we) begin
        if (cfg_index == rtcms_pkg::CFG_SHORT_WRAP)
          mdl_short_wrap = cfg_wdata;
        else if (cfg_index == rtcms_pkg::CFG_RATE_SEL)
          mdl_rate_sel = cfg_wdata;
      end
      // input side
      if (in_tvalid && in_tready)
        expected_time_q.push_back(advance_timer(in_tuser, in_tdata[31:0],
                                                in_tdata[63:32]));
    end
    pending_count = expected_time_q.size();
  end

endmodule

[tb/sv/tb_rtc_tick_millisecond_timer.sv]
// ----------------------------------------------------------------------------
// tb_rtc_tick_millisecond_timer
// Drives the RTC millisecond timer with directed corner cases (clears at the
// counter extremes, full and short wraps, readings past the short wrap
// point, unused codes, both rates) and then four phases of tick sequences
// with random steps, one per wrap mode and rate setting. Both channels stall
// at random except in the third phase; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rtc_tick_millisecond_timer;

  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_ITEMS    = 482;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] rtc_ticks, [63:32] reference_ms
  logic [2:0]  in_tuser   = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] time_ms

  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  logic        no_stall    = 1'b0;
  logic        short_mode  = 1'b0;
  logic [31:0] tick_now;

  rtc_tick_millisecond_timer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rtcms_time_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_tready <= no_stall || ($urandom_range(99) >= 21);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One input transaction; called and returns at a falling edge
  task automatic send_op(input logic [2:0] func, input logic [31:0] ticks,
                         input logic [31:0] ref_ms);
    while (!no_stall && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {ref_ms, ticks};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stop sending and wait for every expected result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Both registers, one per cycle, while idle
  task automatic set_mode(input logic short_wrap, input logic rate_sel);
    cfg_we    <= 1'b1;
    cfg_index <= rtcms_pkg::CFG_SHORT_WRAP;
    cfg_wdata <= short_wrap;
    @(negedge clk);
    cfg_index <= rtcms_pkg::CFG_RATE_SEL;
    cfg_wdata <= rate_sel;
    @(negedge clk);
    cfg_we    <= 1'b0;
    short_mode = short_wrap;
    @(negedge clk);
  endtask

  // Advance the tick counter; keep it under the short wrap point if needed
  task automatic step_ticks();
    if ($urandom_range(99) < 10)
      tick_now = tick_now + $urandom;
    else
      tick_now = tick_now + $urandom_range(50000);
    if (short_mode && tick_now >= rtcms_pkg::SHORT_WRAP_POINT)
      tick_now = tick_now - rtcms_pkg::SHORT_WRAP_POINT;
  endtask

  // Random part: mostly coherent tick sequences, some noise
  task automatic run_phase(input int n_items);
    int          pick;
    logic [2:0]  func;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        func = 3'($urandom_range(FUNC_RSVD_LAST));
        send_op(func, $urandom, $urandom);
      end else if (pick < 22) begin
        step_ticks();
        send_op(rtcms_pkg::FUNC_CLEAR, tick_now, $urandom);
      end else begin
        step_ticks();
        func = 3'($urandom_range(rtcms_pkg::FUNC_ELAPSED16, rtcms_pkg::FUNC_READ32));
        send_op(func, tick_now, $urandom);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full wrap, 32768 Hz (reset setting)
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0000, 32'h0000_0000);  // read before any clear
    send_op(rtcms_pkg::FUNC_CLEAR,     32'hFFFF_FFF0, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0010, 32'h0000_0000);  // base crossed zero
    send_op(rtcms_pkg::FUNC_READ16,    32'h8000_0000, 32'hFFFF_FFFF);
    send_op(rtcms_pkg::FUNC_READ32,    32'hFFFF_FFEF, 32'h0000_0000);  // largest elapsed count
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0000, 32'h0000_0000);  // counter wrapped
    send_op(rtcms_pkg::FUNC_ELAPSED32, 32'h0000_03E8, 32'hFFFF_FFFF);
    send_op(rtcms_pkg::FUNC_ELAPSED16, 32'h0000_1388, 32'hFFFF_FFFF);
    for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++)
      send_op(3'(f), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(rtcms_pkg::FUNC_ELAPSED32, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_results();

    // Short wrap, 32000 Hz; state carries across the switch
    set_mode(1'b1, 1'b1);
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0100, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_CLEAR,     32'hA000_0000, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_READ32,    32'hA8BF_FFFF, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0005, 32'h0000_0000);  // reading below base
    send_op(rtcms_pkg::FUNC_READ16,    32'hFFFF_FFFF, 32'h0000_0000);  // past the wrap point
    send_op(rtcms_pkg::FUNC_ELAPSED16, 32'hA8C0_0000, 32'h0000_0000);
    drain_results();

    set_mode(1'b0, 1'b1);
    send_op(rtcms_pkg::FUNC_READ32,    32'h1234_5678, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0000, 32'h0000_0000);
    drain_results();

    set_mode(1'b1, 1'b0);
    send_op(rtcms_pkg::FUNC_READ32,    32'h0000_0003, 32'h0000_0000);
    send_op(rtcms_pkg::FUNC_ELAPSED32, 32'hA8C0_0001, 32'h0000_FFFF);
    drain_results();

    // Random phases over all four settings; third phase runs without stalls
    for (int p = 0; p < 4; p++) begin
      set_mode(p[0], p[1]);
      no_stall = (p == 2);
      tick_now = $urandom;
      if (short_mode && tick_now >= rtcms_pkg::SHORT_WRAP_POINT)
        tick_now = tick_now - rtcms_pkg::SHORT_WRAP_POINT;
      send_op(rtcms_pkg::FUNC_CLEAR, tick_now, $urandom);
      run_phase(PHASE_ITEMS);
      drain_results();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/rtcms_pkg.sv
design/rtcms_state.sv
design/rtc_tick_millisecond_timer.sv
tb/sv/rtcms_time_checker.sv
tb/sv/tb_rtc_tick_millisecond_timer.sv
